[design/aoc_pkg.sv]
`default_nettype none

package aoc_pkg;

	localparam int unsigned RAW_W   = 12;
	localparam int unsigned SCALE_W = 36;
	localparam int unsigned VAL_W   = 40;
	localparam int unsigned PROD_W  = SCALE_W + RAW_W;
	localparam int unsigned DIVR_W  = 14;
	localparam int unsigned DIV_STEPS = PROD_W;
	localparam int unsigned CNT_W   = $clog2(DIV_STEPS);
	localparam int unsigned IDX_W   = 3;

	localparam logic [VAL_W-1:0] OPEN_VALUE = {VAL_W{1'b1}};
	localparam logic [VAL_W-1:0] SAT_VALUE  = {{(VAL_W-1){1'b1}}, 1'b0};

	// range selection and window thresholds
	localparam logic [RAW_W-1:0] SEL_OHM_BELOW    = 12'd400;
	localparam logic [RAW_W-1:0] SEL_MOHM_ABOVE   = 12'd3630;
	localparam logic [RAW_W-1:0] OHM_LEAVE_ABOVE  = 12'd3370;
	localparam logic [RAW_W-1:0] MOHM_LEAVE_BELOW = 12'd420;
	localparam logic [RAW_W-1:0] OHM_SHORT_MAX    = 12'd120;
	localparam logic [RAW_W-1:0] OHM_QUAD_MAX     = 12'd520;
	localparam logic [RAW_W-1:0] KOHM_OPEN_MIN    = 12'd4000;
	localparam logic [RAW_W-1:0] KOHM_SHORT_MAX   = 12'd37;

	// low-ohm fit: (x * (QUAD_LIN - QUAD_SQ * x) - QUAD_OFS_RND) / QUAD_DIV
	localparam int unsigned QUAD_T_W = 20;
	localparam logic [QUAD_T_W-1:0] QUAD_LIN = 20'd364000;
	localparam logic [QUAD_T_W-1:0] QUAD_SQ  = 20'd138;
	localparam logic [PROD_W-1:0] QUAD_OFS   = 48'd35400000;
	localparam logic [PROD_W-1:0] QUAD_OFS_RND = 48'd35395000;
	localparam logic [DIVR_W-1:0] QUAD_DIV   = 14'd10000;

	// register reset values
	localparam logic [SCALE_W-1:0] OHM_GAIN_RST   = 36'd97600;
	localparam logic [RAW_W-1:0]   OHM_ZERO_RST   = 12'd113;
	localparam logic [RAW_W-1:0]   OHM_OPEN_RST   = 12'd3987;
	localparam logic [SCALE_W-1:0] KOHM_GAIN_RST  = 36'd5250000;
	localparam logic [RAW_W-1:0]   KOHM_ZERO_RST  = 12'd76;
	localparam logic [RAW_W-1:0]   KOHM_OPEN_RST  = 12'd3971;
	localparam logic [SCALE_W-1:0] MOHM_GAIN_RST  = 36'd328000000;
	localparam logic [RAW_W-1:0]   MOHM_OPEN_RST  = 12'd2657;

	typedef enum logic [1:0] {
		RANGE_OHM    = 2'd0,
		RANGE_KOHM   = 2'd1,
		RANGE_MOHM   = 2'd2,
		RANGE_UNUSED = 2'd3
	} range_t;

	typedef enum logic [IDX_W-1:0] {
		REG_OHM_GAIN   = 3'd0,
		REG_OHM_ZERO   = 3'd1,
		REG_OHM_OPEN   = 3'd2,
		REG_KOHM_GAIN  = 3'd3,
		REG_KOHM_ZERO  = 3'd4,
		REG_KOHM_OPEN  = 3'd5,
		REG_MOHM_GAIN  = 3'd6,
		REG_MOHM_OPEN  = 3'd7
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_LOAD = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

endpackage

`default_nettype wire

[design/autorange_ohmmeter_converter.sv]
// Autoranging ohmmeter converter.
// Input channel (in_valid/in_ready, sample_raw): one averaged ADC reading per
// request, taken in the range last shown on range_select.
// Output channel (out_valid/out_ready): one result per input request with the
// range for the next sample, the measure flag, the shown resistance in
// milliohms (all ones = open) and whether this sample updated it.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready,
// writes scale/zero/open registers; they are to be written only while the
// block is idle, a rule on the user that the block does not enforce. Selection,
// window exits and short/open results go from accept straight to the commit
// state; a divider conversion runs a multiply, a load, 48 restoring division
// steps and the commit, taking no new request until then; the 36x12 multiplier
// and bit-serial divider serve both the divider formula and the fit.
// in_ready is high only when the sequencer is idle; a finished result is held
// in the output register, and the next request may already be accepted.
// If the receiver stalls, the following result waits in the commit state and
// the state (range, measure flag, shown value) only advances once the output
// register is free, so no result is lost or overwritten.
// Reset: selection pending, kilohm range, shown value open, no result valid,
// registers at their default calibration.
`default_nettype none

module autorange_ohmmeter_converter #(
	parameter int unsigned MOHM_ZERO_RAW = 75
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [aoc_pkg::RAW_W-1:0]        sample_raw,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [1:0]                       range_select,
	output logic                             measuring,
	output logic [aoc_pkg::VAL_W-1:0]        shown_milliohm,
	output logic                             updated,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [aoc_pkg::IDX_W-1:0]        cfg_index,
	input  wire  [aoc_pkg::SCALE_W-1:0]      cfg_data
);

	localparam logic [aoc_pkg::RAW_W-1:0] MOHM_ZERO = aoc_pkg::RAW_W'(MOHM_ZERO_RAW);

	// calibration registers
	logic [aoc_pkg::SCALE_W-1:0] ohm_gain_q, kohm_gain_q, mohm_gain_q;
	logic [aoc_pkg::RAW_W-1:0]   ohm_zero_q, ohm_open_q, kohm_zero_q, kohm_open_q;
	logic [aoc_pkg::RAW_W-1:0]   mohm_open_q;

	// architectural state
	logic                        selecting_q;
	aoc_pkg::range_t             range_q;
	logic [aoc_pkg::VAL_W-1:0]   shown_q;
	logic                        updated_q;
	logic                        out_valid_q;

	// sequencer
	aoc_pkg::state_t             state_q;
	logic [aoc_pkg::RAW_W-1:0]   x_q;
	logic                        sel_pend_q;
	aoc_pkg::range_t             range_pend_q;
	logic                        upd_pend_q;
	logic                        quad_q;
	logic [aoc_pkg::VAL_W-1:0]   val_q;
	logic [aoc_pkg::PROD_W-1:0]  prod_q;
	logic [aoc_pkg::PROD_W-1:0]  quo_q;
	logic [aoc_pkg::DIVR_W-1:0]  rem_q;
	logic [aoc_pkg::DIVR_W-1:0]  divr_q;
	logic [aoc_pkg::CNT_W-1:0]   cnt_q;

	logic                        in_acc;
	logic                        commit;

	// decode of an accepted sample
	logic                        a_sel;
	aoc_pkg::range_t             a_range;
	logic                        a_upd;
	logic                        a_div;
	logic                        a_quad;
	logic [aoc_pkg::VAL_W-1:0]   a_val;

	// shared datapath
	logic [aoc_pkg::SCALE_W-1:0]  cur_scale;
	logic [aoc_pkg::RAW_W-1:0]    cur_zero;
	logic [aoc_pkg::RAW_W-1:0]    cur_open;
	logic [aoc_pkg::QUAD_T_W-1:0] quad_t;
	logic [aoc_pkg::SCALE_W-1:0]  mul_a;
	logic [aoc_pkg::RAW_W-1:0]    mul_b;
	logic [aoc_pkg::PROD_W-1:0]   dvd;
	logic [aoc_pkg::DIVR_W:0]     trial;
	logic                         q_bit;
	logic [aoc_pkg::DIVR_W-1:0]   rem_n;
	logic [aoc_pkg::PROD_W-1:0]   quo_n;
	logic [aoc_pkg::VAL_W-1:0]    quo_sat;

	assign in_ready  = (state_q == aoc_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign commit    = (state_q == aoc_pkg::ST_FIN) && (!out_valid_q || out_ready);
	assign cfg_ready = 1'b1;

	assign out_valid      = out_valid_q;
	assign range_select   = range_q;
	assign measuring      = !selecting_q;
	assign shown_milliohm = shown_q;
	assign updated        = updated_q;

	// range pick, window check and the cases that need no arithmetic
	always_comb begin
		a_sel   = 1'b0;
		a_range = range_q;
		a_upd   = 1'b0;
		a_div   = 1'b0;
		a_quad  = 1'b0;
		a_val   = '0;
		if (selecting_q) begin
			if (sample_raw < aoc_pkg::SEL_OHM_BELOW) begin
				a_range = aoc_pkg::RANGE_OHM;
			end else if (sample_raw > aoc_pkg::SEL_MOHM_ABOVE) begin
				a_range = aoc_pkg::RANGE_MOHM;
			end else begin
				a_range = aoc_pkg::RANGE_KOHM;
			end
		end else begin
			unique case (range_q)
				aoc_pkg::RANGE_OHM: begin
					if (sample_raw > aoc_pkg::OHM_LEAVE_ABOVE) begin
						a_sel = 1'b1;
					end else begin
						a_upd = 1'b1;
						if (sample_raw <= aoc_pkg::OHM_SHORT_MAX) begin
							a_val = '0;
						end else if (sample_raw <= aoc_pkg::OHM_QUAD_MAX) begin
							a_div  = 1'b1;
							a_quad = 1'b1;
						end else if (sample_raw >= ohm_open_q) begin
							a_val = aoc_pkg::OPEN_VALUE;
						end else if (sample_raw <= ohm_zero_q) begin
							a_val = '0;
						end else begin
							a_div = 1'b1;
						end
					end
				end
				aoc_pkg::RANGE_KOHM: begin
					if (sample_raw < aoc_pkg::SEL_OHM_BELOW
							|| sample_raw > aoc_pkg::SEL_MOHM_ABOVE) begin
						a_sel = 1'b1;
					end else begin
						a_upd = 1'b1;
						if (sample_raw >= aoc_pkg::KOHM_OPEN_MIN) begin
							a_val = aoc_pkg::OPEN_VALUE;
						end else if (sample_raw <= aoc_pkg::KOHM_SHORT_MAX) begin
							a_val = '0;
						end else if (sample_raw >= kohm_open_q) begin
							a_val = aoc_pkg::OPEN_VALUE;
						end else if (sample_raw <= kohm_zero_q) begin
							a_val = '0;
						end else begin
							a_div = 1'b1;
						end
					end
				end
				aoc_pkg::RANGE_MOHM: begin
					if (sample_raw < aoc_pkg::MOHM_LEAVE_BELOW) begin
						a_sel = 1'b1;
					end else begin
						a_upd = 1'b1;
						if (sample_raw <= MOHM_ZERO) begin
							a_val = '0;
						end else if (sample_raw >= mohm_open_q) begin
							a_val = aoc_pkg::OPEN_VALUE;
						end else begin
							a_div = 1'b1;
						end
					end
				end
				aoc_pkg::RANGE_UNUSED: begin
					a_upd = 1'b1;
					a_val = '0;
				end
			endcase
			if (a_sel) begin
				a_range = aoc_pkg::RANGE_KOHM;
			end
		end
	end

	// per-range calibration for the shared multiplier and divider
	always_comb begin
		case (range_q)
			aoc_pkg::RANGE_OHM: begin
				cur_scale = ohm_gain_q;
				cur_zero  = ohm_zero_q;
				cur_open  = ohm_open_q;
			end
			aoc_pkg::RANGE_KOHM: begin
				cur_scale = kohm_gain_q;
				cur_zero  = kohm_zero_q;
				cur_open  = kohm_open_q;
			end
			default: begin
				cur_scale = mohm_gain_q;
				cur_zero  = MOHM_ZERO;
				cur_open  = mohm_open_q;
			end
		endcase
	end

	// low-ohm fit folded as x * (lin - sq * x); only used for x <= 520
	assign quad_t = aoc_pkg::QUAD_LIN
		- aoc_pkg::QUAD_T_W'(aoc_pkg::QUAD_SQ * aoc_pkg::QUAD_T_W'(x_q));
	assign mul_a  = quad_q ? aoc_pkg::SCALE_W'(quad_t) : cur_scale;
	assign mul_b  = quad_q ? x_q : x_q - cur_zero;

	// dividend: fit clamps negatives to zero and adds half the divisor
	always_comb begin
		if (!quad_q) begin
			dvd = prod_q;
		end else if (prod_q >= aoc_pkg::QUAD_OFS) begin
			dvd = prod_q - aoc_pkg::QUAD_OFS_RND;
		end else begin
			dvd = '0;
		end
	end

	// restoring division, one quotient bit per cycle
	assign trial   = {rem_q, quo_q[aoc_pkg::PROD_W-1]};
	assign q_bit   = (trial >= {1'b0, divr_q});
	assign rem_n   = q_bit ? aoc_pkg::DIVR_W'(trial - {1'b0, divr_q})
		: trial[aoc_pkg::DIVR_W-1:0];
	assign quo_n   = {quo_q[aoc_pkg::PROD_W-2:0], q_bit};
	assign quo_sat = ((|quo_n[aoc_pkg::PROD_W-1:aoc_pkg::VAL_W])
		|| (quo_n[aoc_pkg::VAL_W-1:0] == aoc_pkg::OPEN_VALUE))
		? aoc_pkg::SAT_VALUE : quo_n[aoc_pkg::VAL_W-1:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ohm_gain_q   <= aoc_pkg::OHM_GAIN_RST;
			ohm_zero_q   <= aoc_pkg::OHM_ZERO_RST;
			ohm_open_q   <= aoc_pkg::OHM_OPEN_RST;
			kohm_gain_q  <= aoc_pkg::KOHM_GAIN_RST;
			kohm_zero_q  <= aoc_pkg::KOHM_ZERO_RST;
			kohm_open_q  <= aoc_pkg::KOHM_OPEN_RST;
			mohm_gain_q  <= aoc_pkg::MOHM_GAIN_RST;
			mohm_open_q  <= aoc_pkg::MOHM_OPEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (aoc_pkg::reg_idx_t'(cfg_index))
				aoc_pkg::REG_OHM_GAIN:   ohm_gain_q   <= cfg_data;
				aoc_pkg::REG_OHM_ZERO:   ohm_zero_q   <= cfg_data[aoc_pkg::RAW_W-1:0];
				aoc_pkg::REG_OHM_OPEN:   ohm_open_q   <= cfg_data[aoc_pkg::RAW_W-1:0];
				aoc_pkg::REG_KOHM_GAIN:  kohm_gain_q  <= cfg_data;
				aoc_pkg::REG_KOHM_ZERO:  kohm_zero_q  <= cfg_data[aoc_pkg::RAW_W-1:0];
				aoc_pkg::REG_KOHM_OPEN:  kohm_open_q  <= cfg_data[aoc_pkg::RAW_W-1:0];
				aoc_pkg::REG_MOHM_GAIN:  mohm_gain_q  <= cfg_data;
				aoc_pkg::REG_MOHM_OPEN:  mohm_open_q  <= cfg_data[aoc_pkg::RAW_W-1:0];
			endcase
		end
	end

	// sequencer and committed state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aoc_pkg::ST_IDLE;
			selecting_q <= 1'b1;
			range_q     <= aoc_pkg::RANGE_KOHM;
			shown_q     <= aoc_pkg::OPEN_VALUE;
			updated_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
				selecting_q <= sel_pend_q;
				range_q     <= range_pend_q;
				updated_q   <= upd_pend_q;
				if (upd_pend_q) begin
					shown_q <= val_q;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				aoc_pkg::ST_IDLE: begin
					if (in_acc) begin
						state_q <= a_div ? aoc_pkg::ST_MUL : aoc_pkg::ST_FIN;
					end
				end
				aoc_pkg::ST_MUL:  state_q <= aoc_pkg::ST_LOAD;
				aoc_pkg::ST_LOAD: state_q <= aoc_pkg::ST_DIV;
				aoc_pkg::ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= aoc_pkg::ST_FIN;
					end
				end
				aoc_pkg::ST_FIN: begin
					if (commit) begin
						state_q <= aoc_pkg::ST_IDLE;
					end
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q          <= sample_raw;
			sel_pend_q   <= a_sel;
			range_pend_q <= a_range;
			upd_pend_q   <= a_upd;
			quad_q       <= a_quad;
			val_q        <= a_val;
		end
		if (state_q == aoc_pkg::ST_MUL) begin
			prod_q <= aoc_pkg::PROD_W'(mul_a) * aoc_pkg::PROD_W'(mul_b);
		end
		if (state_q == aoc_pkg::ST_LOAD) begin
			quo_q  <= dvd;
			rem_q  <= '0;
			cnt_q  <= aoc_pkg::CNT_W'(aoc_pkg::DIV_STEPS - 1);
			divr_q <= quad_q ? aoc_pkg::QUAD_DIV : aoc_pkg::DIVR_W'(cur_open - x_q);
		end
		if (state_q == aoc_pkg::ST_DIV) begin
			quo_q <= quo_n;
			rem_q <= rem_n;
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				val_q <= quo_sat;
			end
		end
	end

`ifndef ASSERT_OFF
	// selection pending always sits on the kilohm range
	a_sel_kohm: assert property (@(posedge clk) disable iff (!arst_n)
		!measuring |-> range_select == aoc_pkg::RANGE_KOHM)
		else $error("selection pending on a range other than kilohm");

	// an update only comes from the measure state
	a_upd_meas: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && updated |-> measuring)
		else $error("display updated while selection pending");

	// the unused range code is never reached
	a_range_ok: assert property (@(posedge clk) disable iff (!arst_n)
		range_select != aoc_pkg::RANGE_UNUSED)
		else $error("unused range code commanded");

	// divisor is never zero while dividing
	a_divr_nz: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == aoc_pkg::ST_DIV |-> divr_q != '0)
		else $error("division by zero");

	// a pending result is never overwritten by a commit
	a_no_ovwr: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> !out_valid_q || out_ready)
		else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

[tb/ohmmeter_reading_checker.sv]
module ohmmeter_reading_checker #(
	parameter int unsigned MOHM_ZERO_RAW = 75
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  wire                          in_ready,
	input  wire  [aoc_pkg::RAW_W-1:0]    sample_raw,
	input  wire                          out_valid,
	input  wire                          out_ready,
	input  wire  [1:0]                   range_select,
	input  wire                          measuring,
	input  wire  [aoc_pkg::VAL_W-1:0]    shown_milliohm,
	input  wire                          updated,
	input  wire                          cfg_valid,
	input  wire                          cfg_ready,
	input  wire  [aoc_pkg::IDX_W-1:0]    cfg_index,
	input  wire  [aoc_pkg::SCALE_W-1:0]  cfg_data,
	output int                           failures,
	output int                           pending,
	output int                           results,
	output int                           updates
);

	localparam logic [39:0] OPEN_MILLIOHM = 40'hFF_FFFF_FFFF;
	localparam logic [39:0] SAT_MILLIOHM  = 40'hFF_FFFF_FFFE;

	localparam logic [11:0] PICK_OHM_BELOW  = 12'd400;
	localparam logic [11:0] PICK_MOHM_ABOVE = 12'd3630;
	localparam logic [11:0] OHM_EXIT_ABOVE  = 12'd3370;
	localparam logic [11:0] MOHM_EXIT_BELOW = 12'd420;
	localparam logic [11:0] OHM_ZERO_TOP    = 12'd120;
	localparam logic [11:0] OHM_FIT_TOP     = 12'd520;
	localparam logic [11:0] KOHM_OPEN_FROM  = 12'd4000;
	localparam logic [11:0] KOHM_ZERO_TOP   = 12'd37;

	typedef struct packed {
		aoc_pkg::range_t rng;
		logic            meas;
		logic [39:0]     shown;
		logic            upd;
	} reading_t;

	reading_t expected_readings[$];

	// calibration copy
	logic [35:0] ohm_gain, kohm_gain, mohm_gain;
	logic [11:0] ohm_zero, ohm_open, kohm_zero, kohm_open, mohm_open;

	// meter state
	logic            sel_pending;
	aoc_pkg::range_t cur_range;
	logic [39:0]     cur_shown;

	function automatic logic [39:0] divider_milliohm(logic [35:0] scale, logic [11:0] x,
			logic [11:0] zero, logic [11:0] open);
		logic [63:0] q;
		if (x >= open)
			return OPEN_MILLIOHM;
		if (x <= zero)
			return '0;
		q = (64'(scale) * 64'(x - zero)) / 64'(open - x);
		if (q > 64'(SAT_MILLIOHM))
			return SAT_MILLIOHM;
		return q[39:0];
	endfunction

	// low-ohm quadratic, rounded half up, negatives clamp to zero
	function automatic logic [39:0] low_ohm_fit(logic [11:0] x);
		longint xs;
		longint num;
		xs = longint'(x);
		num = 64'sd364000 * xs - 64'sd138 * xs * xs - 64'sd35400000;
		if (num < 0)
			return '0;
		return 40'((num + 64'sd5000) / 64'sd10000);
	endfunction

	function automatic reading_t next_reading(logic [11:0] x);
		reading_t    r;
		logic [39:0] val;
		logic        leave;
		val = '0;
		leave = 1'b0;
		r.upd = 1'b0;
		if (sel_pending) begin
			if (x < PICK_OHM_BELOW)
				cur_range = aoc_pkg::RANGE_OHM;
			else if (x > PICK_MOHM_ABOVE)
				cur_range = aoc_pkg::RANGE_MOHM;
			else
				cur_range = aoc_pkg::RANGE_KOHM;
			sel_pending = 1'b0;
		end else begin
			case (cur_range)
				aoc_pkg::RANGE_OHM: begin
					if (x <= OHM_ZERO_TOP)
						val = '0;
					else if (x <= OHM_FIT_TOP)
						val = low_ohm_fit(x);
					else
						val = divider_milliohm(ohm_gain, x, ohm_zero, ohm_open);
					leave = (x > OHM_EXIT_ABOVE);
				end
				aoc_pkg::RANGE_KOHM: begin
					if (x >= KOHM_OPEN_FROM)
						val = OPEN_MILLIOHM;
					else if (x <= KOHM_ZERO_TOP)
						val = '0;
					else
						val = divider_milliohm(kohm_gain, x, kohm_zero, kohm_open);
					leave = (x < PICK_OHM_BELOW) || (x > PICK_MOHM_ABOVE);
				end
				aoc_pkg::RANGE_MOHM: begin
					if (x <= 12'(MOHM_ZERO_RAW))
						val = '0;
					else if (x >= mohm_open)
						val = OPEN_MILLIOHM;
					else
						val = divider_milliohm(mohm_gain, x, 12'(MOHM_ZERO_RAW), mohm_open);
					leave = (x < MOHM_EXIT_BELOW);
				end
				default: val = '0;
			endcase
			if (leave) begin
				sel_pending = 1'b1;
				cur_range = aoc_pkg::RANGE_KOHM;
			end else begin
				cur_shown = val;
				r.upd = 1'b1;
			end
		end
		r.rng = cur_range;
		r.meas = !sel_pending;
		r.shown = cur_shown;
		return r;
	endfunction

	task automatic report_field(string name, logic [39:0] exp_val, logic [39:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, got_val);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t oldest;
		if (!arst_n) begin
			ohm_gain    = aoc_pkg::OHM_GAIN_RST;
			ohm_zero    = aoc_pkg::OHM_ZERO_RST;
			ohm_open    = aoc_pkg::OHM_OPEN_RST;
			kohm_gain   = aoc_pkg::KOHM_GAIN_RST;
			kohm_zero   = aoc_pkg::KOHM_ZERO_RST;
			kohm_open   = aoc_pkg::KOHM_OPEN_RST;
			mohm_gain   = aoc_pkg::MOHM_GAIN_RST;
			mohm_open   = aoc_pkg::MOHM_OPEN_RST;
			sel_pending = 1'b1;
			cur_range   = aoc_pkg::RANGE_KOHM;
			cur_shown   = OPEN_MILLIOHM;
			expected_readings.delete();
			failures = 0;
			results  = 0;
			updates  = 0;
			pending  = 0;
		end else begin
			// result first: a request taken this edge cannot already be out
			if (out_valid && out_ready) begin
				results++;
				if (updated === 1'b1)
					updates++;
				if (expected_readings.size() == 0) begin
					$display("%0t: result with nothing expected, range %0d shown %h", $time,
						range_select, shown_milliohm);
					failures++;
				end else begin
					oldest = expected_readings.pop_front();
					report_field("range_select", 40'(oldest.rng), 40'(range_select));
					report_field("measuring", 40'(oldest.meas), 40'(measuring));
					report_field("shown_milliohm", oldest.shown, shown_milliohm);
					report_field("updated", 40'(oldest.upd), 40'(updated));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (aoc_pkg::reg_idx_t'(cfg_index))
					aoc_pkg::REG_OHM_GAIN:  ohm_gain  = cfg_data;
					aoc_pkg::REG_OHM_ZERO:  ohm_zero  = cfg_data[11:0];
					aoc_pkg::REG_OHM_OPEN:  ohm_open  = cfg_data[11:0];
					aoc_pkg::REG_KOHM_GAIN: kohm_gain = cfg_data;
					aoc_pkg::REG_KOHM_ZERO: kohm_zero = cfg_data[11:0];
					aoc_pkg::REG_KOHM_OPEN: kohm_open = cfg_data[11:0];
					aoc_pkg::REG_MOHM_GAIN: mohm_gain = cfg_data;
					aoc_pkg::REG_MOHM_OPEN: mohm_open = cfg_data[11:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_readings.push_back(next_reading(sample_raw));
			pending = expected_readings.size();
		end
	end

endmodule

[tb/tb_autorange_ohmmeter_converter.sv]
module tb_autorange_ohmmeter_converter;

	localparam int RAND_PER_PHASE = 75;  // seven calibration phases
	localparam int IDLE_PAUSE     = 64;  // longer than the longest conversion
	localparam int WATCHDOG_LIMIT = 2000;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [aoc_pkg::RAW_W-1:0]     sample_raw;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [1:0]                    range_select;
	logic                          measuring;
	logic [aoc_pkg::VAL_W-1:0]     shown_milliohm;
	logic                          updated;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [aoc_pkg::IDX_W-1:0]     cfg_index;
	logic [aoc_pkg::SCALE_W-1:0]   cfg_data;

	int failures, pending, results, updates;
	int samples_sent = 0;
	int settings_done = 0;
	int quiet_cycles = 0;

	// receiver stall state
	int  stall_left = 0;
	int  spell_left = 0;
	bit  calm = 1'b0;

	// the block's mode as the stimulus sees it, used only to aim the samples
	logic            stim_selecting = 1'b1;
	aoc_pkg::range_t stim_range = aoc_pkg::RANGE_KOHM;

	logic [aoc_pkg::SCALE_W-1:0] cal_set [8];

	// walks ohm through zero, fit and divider, megohm through divider and open,
	// then out of each window; the last requests probe the selection thresholds
	int unsigned directed_samples [25] = '{
		0, 0, 120, 121, 520, 521, 3370, 3371,
		4095, 420, 2656, 2657, 4095, 419,
		3631, 419,
		3630, 400, 3630, 2048, 399,
		399, 4095,
		400, 3631
	};

	always #5 clk = ~clk;

	autorange_ohmmeter_converter i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample_raw     (sample_raw),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.range_select   (range_select),
		.measuring      (measuring),
		.shown_milliohm (shown_milliohm),
		.updated        (updated),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	ohmmeter_reading_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample_raw     (sample_raw),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.range_select   (range_select),
		.measuring      (measuring),
		.shown_milliohm (shown_milliohm),
		.updated        (updated),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.failures       (failures),
		.pending        (pending),
		.results        (results),
		.updates        (updates)
	);

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// Receiver: alternates calm spells (always ready) with spells of random stalls.
	always @(negedge clk) begin
		if (spell_left == 0) begin
			calm = ($urandom_range(0, 3) == 0);
			spell_left = $urandom_range(100, 400);
		end else begin
			spell_left--;
		end
		if (calm) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left = pick_gap() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog: any handshake clears the count of quiet cycles.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One request on the sample channel. With gap 0 valid stays high from the
	// previous request, so it gets exactly one assignment at this edge.
	task automatic send_sample(input logic [aoc_pkg::RAW_W-1:0] x, input int gap);
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		sample_raw <= x;
		do @(posedge clk); while (!in_ready);
		samples_sent++;
		// follow the mode so the next sample can be aimed
		if (stim_selecting) begin
			if (x < aoc_pkg::SEL_OHM_BELOW)
				stim_range = aoc_pkg::RANGE_OHM;
			else if (x > aoc_pkg::SEL_MOHM_ABOVE)
				stim_range = aoc_pkg::RANGE_MOHM;
			else
				stim_range = aoc_pkg::RANGE_KOHM;
			stim_selecting = 1'b0;
		end else if ((stim_range == aoc_pkg::RANGE_OHM && x > aoc_pkg::OHM_LEAVE_ABOVE) ||
				(stim_range == aoc_pkg::RANGE_KOHM &&
				(x < aoc_pkg::SEL_OHM_BELOW || x > aoc_pkg::SEL_MOHM_ABOVE)) ||
				(stim_range == aoc_pkg::RANGE_MOHM && x < aoc_pkg::MOHM_LEAVE_BELOW)) begin
			stim_selecting = 1'b1;
			stim_range = aoc_pkg::RANGE_KOHM;
		end
	endtask

	// Mostly well-formed: a selection sample aimed at a range, then in-window
	// readings with random content; about one in eight is noise across the
	// whole scale, which also forces the window exits.
	task automatic run_random(input int count);
		logic [aoc_pkg::RAW_W-1:0] x;
		int                        gap;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 12) begin
				x = 12'($urandom_range(0, 4095));
			end else if (stim_selecting) begin
				case ($urandom_range(0, 2))
					0: x = 12'($urandom_range(0, 399));
					1: x = 12'($urandom_range(400, 3630));
					default: x = 12'($urandom_range(3631, 4095));
				endcase
			end else begin
				case (stim_range)
					aoc_pkg::RANGE_OHM: begin
						if ($urandom_range(0, 2) == 0)
							x = 12'($urandom_range(0, 520));
						else
							x = 12'($urandom_range(0, 3370));
					end
					aoc_pkg::RANGE_KOHM: x = 12'($urandom_range(400, 3630));
					default:             x = 12'($urandom_range(420, 4095));
				endcase
			end
			// every fourth block of 30 requests runs back to back
			if (((i / 30) % 4) == 1 || $urandom_range(0, 1) == 0)
				gap = 0;
			else
				gap = pick_gap();
			send_sample(x, gap);
		end
	endtask

	// Drop valid, wait for every outstanding result, then let the block settle.
	task automatic settle();
		@(negedge clk) in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (IDLE_PAUSE) @(posedge clk);
	endtask

	task automatic write_calibration();
		for (int i = 0; i < 8; i++) begin
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= aoc_pkg::IDX_W'(i);
			cfg_data  <= cal_set[i];
			do @(posedge clk); while (!cfg_ready);
		end
		@(negedge clk) cfg_valid <= 1'b0;
		settings_done++;
	endtask

	// Calibration for each phase after the first (which runs on reset values):
	// saturating scales, all zero, all ones (raw fields masked), two random
	// sets, then the reset values written back.
	task automatic build_calibration(input int phase);
		bit is_scale, is_zero;
		for (int i = 0; i < 8; i++) begin
			is_scale = (i == aoc_pkg::REG_OHM_GAIN) || (i == aoc_pkg::REG_KOHM_GAIN) ||
				(i == aoc_pkg::REG_MOHM_GAIN);
			is_zero = (i == aoc_pkg::REG_OHM_ZERO) || (i == aoc_pkg::REG_KOHM_ZERO);
			case (phase)
				1: cal_set[i] = is_scale ? {aoc_pkg::SCALE_W{1'b1}} :
					(is_zero ? '0 : 36'd4095);
				2: cal_set[i] = '0;
				3: cal_set[i] = {aoc_pkg::SCALE_W{1'b1}};
				4, 5: begin
					if (is_scale)
						cal_set[i] = ($urandom_range(0, 1) == 1) ? 36'({$urandom, $urandom}) :
							36'($urandom_range(0, 20000000));
					else if (is_zero)
						cal_set[i] = 36'($urandom_range(0, 1500));
					else
						cal_set[i] = 36'($urandom_range(1000, 4095));
				end
				default: begin
					case (aoc_pkg::reg_idx_t'(i))
						aoc_pkg::REG_OHM_GAIN:  cal_set[i] = aoc_pkg::OHM_GAIN_RST;
						aoc_pkg::REG_OHM_ZERO:  cal_set[i] = 36'(aoc_pkg::OHM_ZERO_RST);
						aoc_pkg::REG_OHM_OPEN:  cal_set[i] = 36'(aoc_pkg::OHM_OPEN_RST);
						aoc_pkg::REG_KOHM_GAIN: cal_set[i] = aoc_pkg::KOHM_GAIN_RST;
						aoc_pkg::REG_KOHM_ZERO: cal_set[i] = 36'(aoc_pkg::KOHM_ZERO_RST);
						aoc_pkg::REG_KOHM_OPEN: cal_set[i] = 36'(aoc_pkg::KOHM_OPEN_RST);
						aoc_pkg::REG_MOHM_GAIN: cal_set[i] = aoc_pkg::MOHM_GAIN_RST;
						default:                cal_set[i] = 36'(aoc_pkg::MOHM_OPEN_RST);
					endcase
				end
			endcase
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		sample_raw = '0;
		cfg_valid  = 1'b0;
		cfg_index  = aoc_pkg::REG_OHM_GAIN;
		cfg_data   = '0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// phase 0: reset calibration, directed walk then random
		foreach (directed_samples[k])
			send_sample(12'(directed_samples[k]), ($urandom_range(0, 1) == 1) ? pick_gap() : 0);
		run_random(RAND_PER_PHASE);

		for (int phase = 1; phase < 7; phase++) begin
			settle();
			build_calibration(phase);
			write_calibration();
			run_random(RAND_PER_PHASE);
		end

		settle();
		$display("summary: %0d samples under %0d calibrations, %0d results checked, %0d updates",
			samples_sent, settings_done + 1, results, updates);
		if (failures == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[filelist.f]
design/aoc_pkg.sv
design/autorange_ohmmeter_converter.sv
tb/ohmmeter_reading_checker.sv
tb/tb_autorange_ohmmeter_converter.sv
